// ===== rtl/lspg_pkg.sv =====
// ----------------------------------------------------------------------------
// lspg_pkg
// Shared types, mode codes, colors and the sine table builder for the LED
// status pattern generator.
// ----------------------------------------------------------------------------
package lspg_pkg;

    localparam int DIVISOR_W = 16;
    localparam int LEVEL_W   = 9;

    localparam logic [2:0] MODE_CLEAN       = 3'd0;
    localparam logic [2:0] MODE_UNCOMMITTED = 3'd1;
    localparam logic [2:0] MODE_CONFLICT    = 3'd2;
    localparam logic [2:0] MODE_RUNNING     = 3'd3;
    localparam logic [2:0] MODE_SUCCESS     = 3'd4;
    localparam logic [2:0] MODE_WARNING     = 3'd5;
    localparam logic [2:0] MODE_ERROR       = 3'd6;
    localparam logic [2:0] MODE_OFFLINE     = 3'd7;

    localparam logic [1:0] REG_BREATHING_PERIOD  = 2'd0;
    localparam logic [1:0] REG_PULSE_PERIOD      = 2'd1;
    localparam logic [1:0] REG_FAST_PULSE_PERIOD = 2'd2;

    localparam logic [15:0] BREATHING_PERIOD_RST  = 16'd3000;
    localparam logic [15:0] PULSE_PERIOD_RST      = 16'd1000;
    localparam logic [15:0] FAST_PULSE_PERIOD_RST = 16'd300;

    localparam int BREATH_GAP = 20;
    localparam int FLASH_GAP  = 100;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    localparam rgb_t COLOR_BLACK  = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
    localparam rgb_t COLOR_WHITE  = '{blue: 8'd255, green: 8'd255, red: 8'd255};
    localparam rgb_t COLOR_GREEN  = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
    localparam rgb_t COLOR_ORANGE = '{blue: 8'd0,   green: 8'd165, red: 8'd255};
    localparam rgb_t COLOR_RED    = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
    localparam rgb_t COLOR_SKY    = '{blue: 8'd255, green: 8'd100, red: 8'd0};
    localparam rgb_t COLOR_GRAY   = '{blue: 8'd100, green: 8'd100, red: 8'd100};
    localparam rgb_t COLOR_AMBER  = '{blue: 8'd0,   green: 8'd200, red: 8'd255};

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    function automatic logic [15:0] eff_period(input logic [15:0] p);
        return (p < 16'd2) ? 16'd2 : p;
    endfunction

    // (1 + sin(2*pi*idx/depth)) / 2 in Q1.8, first-quadrant Taylor series
    function automatic logic [LEVEL_W-1:0] sine_entry(input int unsigned idx,
                                                      input int unsigned depth);
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] v;
        logic        neg;
        int          k;
        a   = (64'(idx) * Q30_TWO_PI) / 64'(depth);
        neg = 1'b0;
        if (a >= Q30_PI) begin
            neg = 1'b1;
            a   = a - Q30_PI;
        end
        if (a > Q30_HALF_PI) begin
            a = Q30_PI - a;
        end
        s    = a;
        term = a;
        for (k = 1; k <= 7; k++) begin
            term = (((term * a) >> 30) * a) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 1) s = s - term;
            else              s = s + term;
        end
        if (s > Q30_ONE) s = Q30_ONE;
        v = neg ? (Q30_ONE - s) : (Q30_ONE + s);
        return LEVEL_W'((v * 64'd256 + Q30_ONE) >> 31);
    endfunction

endpackage

// ===== rtl/lspg_serial_div.sv =====
// ----------------------------------------------------------------------------
// lspg_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module lspg_serial_div
    import lspg_pkg::*;
#(
    parameter int NUM_W  = 32,
    parameter int QUOT_W = 9,
    parameter int CNT_W  = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,       // left aligned
    input  logic [CNT_W-1:0]     nbits,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [QUOT_W-1:0]    quot,
    output logic [DIVISOR_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            num_next  = num;
            cnt_next  = nbits;
            div_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        cnt_reg  <= cnt_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(start) |-> rem_reg < div_reg)
        else $error("remainder not below divisor");
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("done without a running division");
`endif

endmodule

// ===== rtl/led_status_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// led_status_pattern_generator_unit
// LED status pattern generator: solid, flashing, breathing and pulse colors.
// ----------------------------------------------------------------------------
// Input words on s_: tuser[0] = 0 for a time tick, 1 for a mode set; tdata
// carries the mode and the millisecond time. A tick may produce one color
// word on m_; a mode set and a tick that comes too early produce none.
// Period registers are written on the cfg_ channel (always ready); the user
// must write them only while the block is idle, which the block does not enforce.
// A mode set leaves the block idle and takes effect in the cycle after acceptance.
// Solid and running ticks go from idle to the emit state, which loads the output
// register once it is free. Breathing and pulse ticks run the bit-serial
// divider twice, once for time mod period and once for the phase scaling,
// before the emit state. One word is in work at a time; s_tready is high while idle.
// The result sits in an output register, so a new word is taken while it
// waits; a stalled receiver holds the block only once the next result is
// ready. Reset restores the period registers, mode clean, flash off and
// last update time zero; no output word is pending after reset.
// ----------------------------------------------------------------------------
module led_status_pattern_generator_unit
    import lspg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int TIME_WIDTH       = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((TIME_WIDTH+3+7)/8)*8-1:0] s_tdata,  // new_mode, now_ms
    input  logic [0:0]                        s_tuser,  // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // red, green, blue
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam int LOG_D  = $clog2(SINE_TABLE_DEPTH);
    localparam int SCL_W  = (LOG_D > 8) ? LOG_D : 8;
    localparam int NUM_W  = (TIME_WIDTH > DIVISOR_W + SCL_W) ? TIME_WIDTH
                                                             : DIVISOR_W + SCL_W;
    localparam int QUOT_W = (LOG_D > LEVEL_W) ? LOG_D : LEVEL_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int PHS_W  = DIVISOR_W + LOG_D;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOD   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic                  cmd;
    logic [2:0]            new_mode;
    logic [TIME_WIDTH-1:0] now_ms;
    logic                  accept;
    logic [TIME_WIDTH-1:0] diff;

    logic [15:0]           breath_period_reg, pulse_period_reg, fast_period_reg;
    logic [1:0]            state_reg, state_next;
    logic [2:0]            mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic                  flash_reg, flash_next;
    logic [15:0]           period_reg, period_next;
    logic                  breathe_reg, breathe_next;
    rgb_t                  color_reg, color_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    rgb_t                  out_reg, out_next;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [CNT_W-1:0]      div_nbits;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic [DIVISOR_W-1:0]  div_rem;

    logic [15:0]           half;
    logic [15:0]           fold;
    logic [16:0]           prod_r, prod_g, prod_b;
    logic [LEVEL_W-1:0]    sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g, SINE_TABLE_DEPTH);
    end

    assign cmd      = s_tuser[0];
    assign new_mode = s_tdata[2:0];
    assign now_ms   = s_tdata[3 +: TIME_WIDTH];
    assign accept   = s_tvalid && s_tready;
    assign diff     = now_ms - last_reg;
    assign half     = period_reg >> 1;
    assign fold     = (div_rem < half) ? div_rem : ((half << 1) - div_rem);

    assign prod_r = 17'(color_reg.red)   * 17'(level_reg);
    assign prod_g = 17'(color_reg.green) * 17'(level_reg);
    assign prod_b = 17'(color_reg.blue)  * 17'(level_reg);

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        last_next     = last_reg;
        flash_next    = flash_reg;
        period_next   = period_reg;
        breathe_next  = breathe_reg;
        color_next    = color_reg;
        level_next    = level_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        div_start     = 1'b0;
        div_num       = NUM_W'(now_ms) << (NUM_W - TIME_WIDTH);
        div_nbits     = CNT_W'(TIME_WIDTH);
        div_divisor   = period_next;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && cmd) begin
                    if (new_mode != mode_reg) begin
                        mode_next  = new_mode;
                        flash_next = 1'b0;
                        last_next  = now_ms;
                    end
                end else if (accept) begin
                    level_next = LEVEL_FULL;
                    unique case (mode_reg)
                        MODE_SUCCESS: begin
                            color_next = COLOR_GREEN;
                            state_next = ST_EMIT;
                        end
                        MODE_WARNING: begin
                            color_next = COLOR_ORANGE;
                            state_next = ST_EMIT;
                        end
                        MODE_ERROR: begin
                            color_next = COLOR_RED;
                            state_next = ST_EMIT;
                        end
                        MODE_RUNNING: begin
                            if (diff > TIME_WIDTH'(FLASH_GAP)) begin
                                last_next  = now_ms;
                                flash_next = !flash_reg;
                                color_next = flash_reg ? COLOR_BLACK : COLOR_WHITE;
                                state_next = ST_EMIT;
                            end
                        end
                        default: begin
                            if (diff > TIME_WIDTH'(BREATH_GAP)) begin
                                last_next  = now_ms;
                                state_next = ST_MOD;
                                div_start  = 1'b1;
                                unique case (mode_reg)
                                    MODE_CLEAN: begin
                                        color_next   = COLOR_SKY;
                                        breathe_next = 1'b1;
                                        period_next  = eff_period(breath_period_reg);
                                    end
                                    MODE_OFFLINE: begin
                                        color_next   = COLOR_GRAY;
                                        breathe_next = 1'b1;
                                        period_next  = eff_period(breath_period_reg);
                                    end
                                    MODE_UNCOMMITTED: begin
                                        color_next   = COLOR_AMBER;
                                        breathe_next = 1'b0;
                                        period_next  = eff_period(pulse_period_reg);
                                    end
                                    default: begin
                                        color_next   = COLOR_RED;
                                        breathe_next = 1'b0;
                                        period_next  = eff_period(fast_period_reg);
                                    end
                                endcase
                                div_divisor = period_next;
                            end
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_SCALE;
                    if (breathe_reg) begin
                        div_num     = NUM_W'(PHS_W'(div_rem) * PHS_W'(SINE_TABLE_DEPTH))
                                      << (NUM_W - PHS_W);
                        div_nbits   = CNT_W'(PHS_W);
                        div_divisor = period_reg;
                    end else begin
                        div_num     = NUM_W'({fold, 8'd0}) << (NUM_W - DIVISOR_W - 8);
                        div_nbits   = CNT_W'(DIVISOR_W + 8);
                        div_divisor = half;
                    end
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                    level_next = breathe_reg ? sine_rom[div_quot[LOG_D-1:0]]
                                             : div_quot[LEVEL_W-1:0];
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_next.red   = prod_r[15:8];
                    out_next.green = prod_g[15:8];
                    out_next.blue  = prod_b[15:8];
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            breath_period_reg <= BREATHING_PERIOD_RST;
            pulse_period_reg  <= PULSE_PERIOD_RST;
            fast_period_reg   <= FAST_PULSE_PERIOD_RST;
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_CLEAN;
            last_reg          <= '0;
            flash_reg         <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_BREATHING_PERIOD:  breath_period_reg <= cfg_data;
                    REG_PULSE_PERIOD:      pulse_period_reg  <= cfg_data;
                    REG_FAST_PULSE_PERIOD: fast_period_reg   <= cfg_data;
                    default: ;
                endcase
            end
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            last_reg     <= last_next;
            flash_reg    <= flash_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        period_reg  <= period_next;
        breathe_reg <= breathe_next;
        color_reg   <= color_next;
        level_reg   <= level_next;
        out_reg     <= out_next;
    end

    lspg_serial_div #(
        .NUM_W  (NUM_W),
        .QUOT_W (QUOT_W),
        .CNT_W  (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .nbits   (div_nbits),
        .divisor (div_divisor),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

`ifndef ASSERT_OFF
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> level_reg <= LEVEL_FULL)
        else $error("brightness above full scale");
    a_div_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_MOD || state_reg == ST_SCALE))
        else $error("divider running outside a calculation");
    a_solid_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cmd && (mode_reg == MODE_SUCCESS || mode_reg == MODE_WARNING
                           || mode_reg == MODE_ERROR) |=> state_reg == ST_EMIT)
        else $error("solid tick did not produce a word");
    a_set_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd |=> state_reg == ST_IDLE)
        else $error("mode set started a calculation");
`endif

endmodule

// ===== test/tb_led_status_pattern_generator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_status_pattern_generator_unit
// Self-checking bench for the LED status pattern generator. A driver feeds
// mode-set and time-tick words from a backlog. A predictor written in this
// bench works out each expected strip color as words are accepted, and a
// monitor checks every color word in order. Period registers are rewritten
// between phases only after the block has drained: minimum, maximum, below
// minimum, odd and random periods. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_led_status_pattern_generator_unit;
    import lspg_pkg::*;

    localparam bit          CMD_TICK      = 1'b0;
    localparam bit          CMD_SET       = 1'b1;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam int unsigned LUT_DEPTH     = 256;
    localparam int unsigned MIN_PERIOD    = 2;
    localparam int unsigned FULL_LEVEL    = 256;
    localparam int unsigned FLASH_MS      = 100;
    localparam int unsigned ANIM_MS       = 20;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          STUCK_LIMIT   = 3000;
    localparam int          PHASE_WORDS   = 145;

    localparam logic [63:0] FX_ONE     = 64'd1073741824;
    localparam logic [63:0] FX_PI      = 64'd3373259426;
    localparam logic [63:0] FX_HALF_PI = 64'd1686629713;
    localparam logic [63:0] FX_TWO_PI  = 64'd6746518852;

    typedef struct packed {
        bit          cmd;
        logic [2:0]  mode;
        logic [31:0] now;
    } status_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // new_mode, now_ms
    logic [0:0]  s_tuser   = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // red, green, blue
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    led_status_pattern_generator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    status_word_t word_backlog[$];
    rgb_t         color_due[$];
    status_word_t on_bus;
    logic [8:0]   sine_lut [LUT_DEPTH];

    logic [2:0]   cur_mode   = MODE_CLEAN;
    logic [31:0]  last_ms    = '0;
    bit           flash_on   = 1'b0;
    logic [15:0]  breath_p   = 16'd3000;
    logic [15:0]  pulse_p    = 16'd1000;
    logic [15:0]  fast_p     = 16'd300;

    logic [31:0]  sim_ms     = '0;
    int unsigned  send_odds  = 4;
    int unsigned  recv_odds  = 4;
    int           send_idle  = 0;
    int           recv_idle  = 0;
    int           stuck_cycles = 0;
    int           mismatches = 0;

    function automatic logic [8:0] sin_level(int unsigned i);
        logic [63:0] ang;
        logic [63:0] acc;
        logic [63:0] trm;
        logic [63:0] mag;
        bit          lower;
        int          n;
        ang   = (64'(i) * FX_TWO_PI) / 64'(LUT_DEPTH);
        lower = 1'b0;
        if (ang >= FX_PI) begin
            lower = 1'b1;
            ang   = ang - FX_PI;
        end
        if (ang > FX_HALF_PI) ang = FX_PI - ang;
        acc = ang;
        trm = ang;
        for (n = 1; n <= 7; n++) begin
            trm = (((trm * ang) >> 30) * ang) >> 30;
            trm = trm / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) acc = acc - trm;
            else            acc = acc + trm;
        end
        if (acc > FX_ONE) acc = FX_ONE;
        mag = lower ? (FX_ONE - acc) : (FX_ONE + acc);
        return 9'((mag * 64'd256 + FX_ONE) >> 31);
    endfunction

    function automatic rgb_t shade(int unsigned r, int unsigned g, int unsigned b,
                                   int unsigned lvl);
        rgb_t c;
        c.red   = 8'((r * lvl) >> 8);
        c.green = 8'((g * lvl) >> 8);
        c.blue  = 8'((b * lvl) >> 8);
        return c;
    endfunction

    function automatic int unsigned breath_lvl(logic [31:0] t, logic [15:0] period_reg);
        longint unsigned p;
        longint unsigned tt;
        longint unsigned idx;
        p   = (period_reg < MIN_PERIOD) ? MIN_PERIOD : period_reg;
        tt  = t;
        idx = ((tt % p) * LUT_DEPTH) / p;
        if (idx >= LUT_DEPTH) idx = LUT_DEPTH - 1;
        return sine_lut[idx];
    endfunction

    function automatic int unsigned pulse_lvl(logic [31:0] t, logic [15:0] period_reg);
        longint unsigned p;
        longint unsigned tt;
        longint unsigned ph;
        longint unsigned half;
        p    = (period_reg < MIN_PERIOD) ? MIN_PERIOD : period_reg;
        tt   = t;
        ph   = tt % p;
        half = p >> 1;
        if (ph < half) return int'((ph * 256) / half);
        return int'(((2 * half - ph) * 256) / half);
    endfunction

    function automatic void predict_color(input status_word_t w, output bit hit,
                                          output rgb_t c);
        logic [31:0] gap;
        hit = 1'b0;
        c   = '0;
        if (w.cmd == CMD_SET) begin
            if (w.mode != cur_mode) begin
                cur_mode = w.mode;
                flash_on = 1'b0;
                last_ms  = w.now;
            end
            return;
        end
        gap = w.now - last_ms;
        case (cur_mode)
            MODE_SUCCESS: begin
                hit = 1'b1;
                c   = shade(0, 255, 0, FULL_LEVEL);
            end
            MODE_WARNING: begin
                hit = 1'b1;
                c   = shade(255, 165, 0, FULL_LEVEL);
            end
            MODE_ERROR: begin
                hit = 1'b1;
                c   = shade(255, 0, 0, FULL_LEVEL);
            end
            MODE_RUNNING: begin
                if (gap > FLASH_MS) begin
                    last_ms  = w.now;
                    flash_on = !flash_on;
                    hit      = 1'b1;
                    c = flash_on ? shade(255, 255, 255, FULL_LEVEL) : shade(0, 0, 0, FULL_LEVEL);
                end
            end
            default: begin
                if (gap > ANIM_MS) begin
                    last_ms = w.now;
                    hit     = 1'b1;
                    case (cur_mode)
                        MODE_CLEAN:       c = shade(0, 100, 255, breath_lvl(w.now, breath_p));
                        MODE_OFFLINE:     c = shade(100, 100, 100, breath_lvl(w.now, breath_p));
                        MODE_UNCOMMITTED: c = shade(255, 200, 0, pulse_lvl(w.now, pulse_p));
                        default:          c = shade(255, 0, 0, pulse_lvl(w.now, fast_p));
                    endcase
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : drive
        status_word_t nxt;
        bit           hit;
        rgb_t         col;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_idle = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_color(on_bus, hit, col);
                if (hit) color_due.push_back(col);
            end
            if (!s_tvalid || s_tready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end else if (word_backlog.size() > 0) begin
                    nxt    = word_backlog.pop_front();
                    on_bus = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, nxt.now, nxt.mode};
                    s_tuser  <= nxt.cmd;
                    if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
                        send_idle = $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : sink
        rgb_t want;
        rgb_t got;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_idle = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                if (color_due.size() == 0) begin
                    flag_mismatch($sformatf("color word %h with none pending", m_tdata));
                end else begin
                    want = color_due.pop_front();
                    if (got.red !== want.red)
                        flag_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
                    if (got.green !== want.green)
                        flag_mismatch($sformatf("green got %0d want %0d",
                                                got.green, want.green));
                    if (got.blue !== want.blue)
                        flag_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
                    recv_idle = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_tick(input logic [31:0] t);
        status_word_t w;
        w.cmd  = CMD_TICK;
        w.mode = 3'($urandom_range(0, 7));
        w.now  = t;
        word_backlog.push_back(w);
    endtask

    task automatic add_set(input logic [2:0] m, input logic [31:0] t);
        status_word_t w;
        w.cmd  = CMD_SET;
        w.mode = m;
        w.now  = t;
        word_backlog.push_back(w);
    endtask

    // hold until every word is taken and every color has come, then let the
    // block finish any word that gives no color
    task automatic settle();
        while (word_backlog.size() > 0 || s_tvalid || color_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_period(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BREATHING_PERIOD:  breath_p = val;
            REG_PULSE_PERIOD:      pulse_p  = val;
            REG_FAST_PULSE_PERIOD: fast_p   = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_periods(input logic [15:0] b, input logic [15:0] p,
                               input logic [15:0] f);
        write_period(REG_BREATHING_PERIOD, b);
        write_period(REG_PULSE_PERIOD, p);
        write_period(REG_FAST_PULSE_PERIOD, f);
    endtask

    // mostly advancing ticks with some mode sets; some raw noise and wraps
    task automatic random_run(input int count);
        int k;
        int pick;
        status_word_t w;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w.cmd  = 1'($urandom_range(0, 1));
                w.mode = 3'($urandom_range(0, 7));
                w.now  = $urandom;
                word_backlog.push_back(w);
            end else if (pick < 20) begin
                add_set(3'($urandom_range(0, 7)), sim_ms);
            end else begin
                if ($urandom_range(0, 59) == 0)
                    sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                else if ($urandom_range(0, 39) == 0)
                    sim_ms = $urandom;
                else if ($urandom_range(0, 3) == 0)
                    sim_ms = sim_ms + $urandom_range(0, 25);
                else
                    sim_ms = sim_ms + $urandom_range(15, 160);
                add_tick(sim_ms);
            end
        end
    endtask

    initial begin : main
        int i;
        for (i = 0; i < LUT_DEPTH; i++) sine_lut[i] = sin_level(i);

        add_tick(32'd0);
        add_tick(32'd21);
        add_tick(32'd41);
        add_tick(32'd42);
        add_set(MODE_CLEAN, 32'd500);
        add_tick(32'd63);
        add_set(MODE_SUCCESS, 32'd100);
        add_tick(32'd100);
        add_set(MODE_WARNING, 32'd200);
        add_tick(32'd0);
        add_set(MODE_ERROR, 32'd300);
        add_tick(32'hFFFF_FFFF);
        add_set(MODE_RUNNING, 32'd1000);
        add_tick(32'd1100);
        add_tick(32'd1101);
        add_set(MODE_RUNNING, 32'd5);
        add_tick(32'd1201);
        add_tick(32'd1202);
        add_set(MODE_UNCOMMITTED, 32'd2000);
        add_tick(32'd2500);
        add_set(MODE_CONFLICT, 32'd3000);
        add_tick(32'd3150);
        add_set(MODE_OFFLINE, 32'd4000);
        add_tick(32'd4750);
        add_set(MODE_CLEAN, 32'hFFFF_FFF0);
        add_tick(32'h0000_0010);
        sim_ms = 32'h0000_0010;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        random_run(PHASE_WORDS);
        settle();

        set_periods(16'd2, 16'd2, 16'd2);
        write_period(REG_UNUSED, 16'hFFFF);
        send_odds = 0;
        recv_odds = 3;
        random_run(PHASE_WORDS);
        settle();

        set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_odds = 3;
        recv_odds = 0;
        random_run(PHASE_WORDS);
        settle();

        set_periods(16'd0, 16'd1, 16'd3);
        write_period(REG_UNUSED, 16'd0);
        send_odds = 2;
        recv_odds = 2;
        random_run(PHASE_WORDS);
        settle();

        set_periods(16'($urandom_range(2, 400)), 16'($urandom_range(2, 65535)),
                    16'($urandom_range(3, 999)));
        send_odds = 6;
        recv_odds = 5;
        random_run(PHASE_WORDS);
        settle();

        set_periods(16'd3001, 16'd999, 16'd301);
        send_odds = 0;
        recv_odds = 0;
        random_run(PHASE_WORDS);
        settle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== led_status_pattern_generator_unit.f =====
rtl/lspg_pkg.sv
rtl/lspg_serial_div.sv
rtl/led_status_pattern_generator_unit.sv
test/tb_led_status_pattern_generator_unit.sv
